[hdl/tdq_pkg.sv]
package tdq_pkg;

   localparam int SLOTS_DEFAULT = 32;
   localparam int ID_W = 6;
   localparam int TIME_W = 64;
   localparam int DELAY_W = 48;
   localparam int ORDER_W = 32;
   localparam int TMO_W = 16;
   localparam int MS_DIV = 1000;

   typedef enum logic [1:0] {
      KIND_REGISTER = 2'd0,
      KIND_REMOVE   = 2'd1,
      KIND_CHECK    = 2'd2,
      KIND_UNUSED   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      RES_REGISTERED = 2'd0,
      RES_REMOVE     = 2'd1,
      RES_EXPIRED    = 2'd2,
      RES_FINAL      = 2'd3
   } res_kind_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [TIME_W-1:0]  now_us;
      logic [DELAY_W-1:0] delay_us;
      logic [ID_W-1:0]    timer_id;
   } req_type;

   typedef struct packed {
      logic [1:0]       result_kind;
      logic [ID_W-1:0]  out_id;
      logic             ok;
      logic             reload_valid;
      logic [TMO_W-1:0] timeout_ms;
      logic             last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture request
      logic scan_clear;  // start min scan
      logic scan_step;   // examine one slot
      logic alloc_step;  // examine one slot for allocation
      logic alloc_clear;
      logic commit_reg;  // store new timer
      logic do_remove;
      logic free_best;   // free found earliest
      logic div_start;
      logic div_step;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       scan_done;
      logic       alloc_done;
      logic       alloc_found;
      logic       have_best;
      logic       best_expired;
      logic       div_done;
      logic [1:0] kind;
   } dp_stat_type;

endpackage

[hdl/tdq_datapath.sv]
module tdq_datapath #(
   parameter int SLOTS = tdq_pkg::SLOTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tdq_pkg::req_type     req_in,
   input  tdq_pkg::dp_cmd_type  cmd,
   output tdq_pkg::dp_stat_type stat,
   output logic [tdq_pkg::ID_W-1:0]  best_id,
   output logic [tdq_pkg::ID_W-1:0]  alloc_id,
   output logic                      remove_ok,
   output logic [tdq_pkg::TMO_W-1:0] tmo
);
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TW = tdq_pkg::TIME_W;
   localparam int OW = tdq_pkg::ORDER_W;
   localparam int IW = tdq_pkg::ID_W;
   localparam int MW = tdq_pkg::TMO_W;
   localparam int RW = 10;       // remainder bits, always below 1000
   localparam int VW = RW + 16;  // remainder followed by one 16-bit digit
   localparam int PW = 53;
   localparam int RECIP_SH = 36;
   // ceil(2^36 / 1000), exact quotient for every dividend below 2^26
   localparam logic [26:0] RECIP = 27'd68719477;

   tdq_pkg::req_type req_ff;
   logic [SLOTS-1:0] valid_ff;
   logic [TW-1:0] deadline_mem [SLOTS];
   logic [OW-1:0] order_mem [SLOTS];
   logic [OW-1:0] order_cnt_ff;
   logic [IW-1:0] next_id_ff;

   logic [SW-1:0] scan_idx_ff;
   logic [SW:0]   scan_cnt_ff;
   logic          have_best_ff;
   logic [SW-1:0] best_ff;
   logic [TW-1:0] best_dl_ff;
   logic [OW-1:0] best_ord_ff;

   logic [IW-1:0] alloc_c_ff;
   logic [SW:0]   alloc_cnt_ff;
   logic          alloc_found_ff;
   logic [IW-1:0] alloc_id_ff;
   logic          remove_ok_ff;

   logic [TW-1:0] dvd_ff;
   logic [RW-1:0] rem_ff;
   logic [MW-1:0] quo_ff;
   logic [3:0]    div_cnt_ff;

   logic [TW-1:0] cur_dl;
   logic [OW-1:0] cur_ord, ord_diff;
   logic          cur_earlier;
   logic [IW-1:0] start_id;
   logic [TW:0]   dl_sum;
   logic [TW-1:0] dl_sat;
   logic [IW-1:0] tid;
   logic          rem_hit;
   logic [VW-1:0] div_v, div_back, div_rem;
   logic [PW-1:0] div_prod;

   assign cur_dl   = deadline_mem[scan_idx_ff];
   assign cur_ord  = order_mem[scan_idx_ff];
   assign ord_diff = cur_ord - best_ord_ff;
   assign cur_earlier = (cur_dl != best_dl_ff) ? (cur_dl < best_dl_ff) : ord_diff[OW-1];
   assign start_id = (next_id_ff < IW'(1) || next_id_ff > IW'(SLOTS)) ? IW'(1) : next_id_ff;
   assign dl_sum = {1'b0, req_ff.now_us} + (TW+1)'(req_ff.delay_us);
   assign dl_sat = dl_sum[TW] ? '1 : dl_sum[TW-1:0];
   assign tid = req_ff.timer_id;
   assign rem_hit = tid >= IW'(1) && tid <= IW'(SLOTS) && valid_ff[SW'(tid - IW'(1))];

   // long division by 1000 in 16-bit digits, a quotient step then a remainder step per digit
   assign div_v    = {rem_ff, dvd_ff[TW-1 -: 16]};
   assign div_prod = PW'(div_v) * PW'(RECIP);
   assign div_back = VW'(quo_ff) * VW'(tdq_pkg::MS_DIV);
   assign div_rem  = div_v - div_back;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         order_cnt_ff <= '0;
         next_id_ff <= IW'(1);
         have_best_ff <= 1'b0;
         scan_cnt_ff <= '0;
         alloc_cnt_ff <= '0;
         alloc_found_ff <= 1'b0;
         div_cnt_ff <= '0;
      end else begin
         if (cmd.load) begin
            req_ff <= req_in;
         end
         if (cmd.scan_clear) begin
            scan_idx_ff <= '0;
            scan_cnt_ff <= '0;
            have_best_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            if (valid_ff[scan_idx_ff] && (!have_best_ff || cur_earlier)) begin
               have_best_ff <= 1'b1;
               best_ff <= scan_idx_ff;
               best_dl_ff <= cur_dl;
               best_ord_ff <= cur_ord;
            end
            scan_idx_ff <= (scan_idx_ff == SW'(SLOTS-1)) ? '0 : scan_idx_ff + SW'(1);
            scan_cnt_ff <= scan_cnt_ff + (SW+1)'(1);
         end
         if (cmd.alloc_clear) begin
            alloc_c_ff <= start_id;
            alloc_cnt_ff <= '0;
            alloc_found_ff <= 1'b0;
            alloc_id_ff <= '0;
         end else if (cmd.alloc_step && !alloc_found_ff) begin
            if (!valid_ff[SW'(alloc_c_ff - IW'(1))]) begin
               alloc_found_ff <= 1'b1;
               alloc_id_ff <= alloc_c_ff;
            end
            alloc_c_ff <= (alloc_c_ff >= IW'(SLOTS)) ? IW'(1) : alloc_c_ff + IW'(1);
            alloc_cnt_ff <= alloc_cnt_ff + (SW+1)'(1);
         end
         if (cmd.commit_reg && alloc_found_ff) begin
            valid_ff[SW'(alloc_id_ff - IW'(1))] <= 1'b1;
            deadline_mem[SW'(alloc_id_ff - IW'(1))] <= dl_sat;
            order_mem[SW'(alloc_id_ff - IW'(1))] <= order_cnt_ff;
            order_cnt_ff <= order_cnt_ff + OW'(1);
            next_id_ff <= (alloc_id_ff >= IW'(SLOTS)) ? IW'(1) : alloc_id_ff + IW'(1);
         end
         if (cmd.do_remove) begin
            remove_ok_ff <= rem_hit;
            if (rem_hit) begin
               valid_ff[SW'(tid - IW'(1))] <= 1'b0;
            end
         end
         if (cmd.free_best) begin
            valid_ff[best_ff] <= 1'b0;
         end
         if (cmd.div_start) begin
            rem_ff <= '0;
            quo_ff <= '0;
            dvd_ff <= (best_dl_ff > req_ff.now_us) ? best_dl_ff - req_ff.now_us : '0;
            div_cnt_ff <= '0;
         end else if (cmd.div_step) begin
            if (!div_cnt_ff[0]) begin
               quo_ff <= div_prod[RECIP_SH+MW-1:RECIP_SH];
            end else begin
               rem_ff <= div_rem[RW-1:0];
               dvd_ff <= {dvd_ff[TW-17:0], 16'b0};
            end
            div_cnt_ff <= div_cnt_ff + 4'd1;
         end
      end
   end

   assign stat.scan_done    = (scan_cnt_ff == (SW+1)'(SLOTS));
   assign stat.alloc_done   = alloc_found_ff || (alloc_cnt_ff == (SW+1)'(SLOTS));
   assign stat.alloc_found  = alloc_found_ff;
   assign stat.have_best    = have_best_ff;
   assign stat.best_expired = (best_dl_ff <= req_ff.now_us);
   // four digits, quotient and remainder step each
   assign stat.div_done     = (div_cnt_ff == 4'd8);
   assign stat.kind         = req_ff.kind;
   assign best_id   = IW'(best_ff) + IW'(1);
   assign alloc_id  = alloc_id_ff;
   assign remove_ok = remove_ok_ff;
   // low 16 bits of the full quotient are the last digit's quotient
   assign tmo       = quo_ff;
endmodule

[hdl/tdq_ctrl.sv]
module tdq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  tdq_pkg::dp_stat_type stat,
   input  logic [tdq_pkg::ID_W-1:0]  best_id,
   input  logic [tdq_pkg::ID_W-1:0]  alloc_id,
   input  logic                      remove_ok,
   input  logic [tdq_pkg::TMO_W-1:0] tmo,
   output tdq_pkg::dp_cmd_type  cmd,
   output logic                 rsp_strobe,
   output tdq_pkg::rsp_type     rsp_data
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_ALLOC, ST_COMMIT, ST_SCAN_START, ST_SCAN,
      ST_DECIDE, ST_DIV, ST_FINISH, ST_REMOVE, ST_REM_OUT
   } state_type;

   state_type state_ff;
   logic rsp_strobe_ff;
   tdq_pkg::rsp_type rsp_ff;
   logic expire_hit;

   assign busy = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_ff;
   assign expire_hit = (stat.kind == tdq_pkg::KIND_CHECK) && stat.have_best &&
                       stat.best_expired;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:       cmd.load = start;
         ST_DECODE:     cmd.alloc_clear = 1'b1;
         ST_ALLOC:      cmd.alloc_step = 1'b1;
         ST_COMMIT:     cmd.commit_reg = 1'b1;
         ST_SCAN_START: cmd.scan_clear = 1'b1;
         ST_SCAN:       cmd.scan_step = !stat.scan_done;
         ST_DECIDE:     begin
            cmd.div_start = 1'b1;
            cmd.free_best = expire_hit;
         end
         ST_DIV:        cmd.div_step = !stat.div_done;
         ST_REMOVE:     cmd.do_remove = 1'b1;
         default:       cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (state_ff == ST_FINISH) || (state_ff == ST_REM_OUT) ||
                          ((state_ff == ST_DECIDE) && expire_hit);
         unique case (state_ff)
            ST_IDLE: if (start) state_ff <= ST_DECODE;
            ST_DECODE: begin
               unique case (stat.kind)
                  tdq_pkg::KIND_REGISTER: state_ff <= ST_ALLOC;
                  tdq_pkg::KIND_REMOVE:   state_ff <= ST_REMOVE;
                  tdq_pkg::KIND_CHECK:    state_ff <= ST_SCAN_START;
                  default:                state_ff <= ST_IDLE;
               endcase
            end
            ST_ALLOC: if (stat.alloc_done) state_ff <= ST_COMMIT;
            ST_COMMIT: state_ff <= ST_SCAN_START;
            ST_SCAN_START: state_ff <= ST_SCAN;
            ST_SCAN: if (stat.scan_done) state_ff <= ST_DECIDE;
            ST_DECIDE: begin
               if (expire_hit) begin
                  rsp_ff <= '{result_kind: tdq_pkg::RES_EXPIRED, out_id: best_id,
                              ok: 1'b0, reload_valid: 1'b0, timeout_ms: '0, last: 1'b0};
                  state_ff <= ST_SCAN_START;
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: if (stat.div_done) state_ff <= ST_FINISH;
            ST_FINISH: begin
               rsp_ff.last <= 1'b1;
               rsp_ff.reload_valid <= stat.have_best;
               rsp_ff.timeout_ms <= stat.have_best ? tmo : '0;
               if (stat.kind == tdq_pkg::KIND_REGISTER) begin
                  rsp_ff.result_kind <= tdq_pkg::RES_REGISTERED;
                  rsp_ff.out_id <= stat.alloc_found ? alloc_id : '0;
                  rsp_ff.ok <= stat.alloc_found;
               end else begin
                  rsp_ff.result_kind <= tdq_pkg::RES_FINAL;
                  rsp_ff.out_id <= '0;
                  rsp_ff.ok <= 1'b0;
               end
               state_ff <= ST_IDLE;
            end
            ST_REMOVE: state_ff <= ST_REM_OUT;
            ST_REM_OUT: begin
               rsp_ff <= '{result_kind: tdq_pkg::RES_REMOVE, out_id: '0, ok: remove_ok,
                           reload_valid: 1'b0, timeout_ms: '0, last: 1'b1};
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

[hdl/timer_deadline_queue.sv]
// channel   ports                           transaction
// request   start, busy, req_data           start high while busy low
// response  rsp_strobe, rsp_data            every cycle rsp_strobe is high
//
// busy is high from the cycle after acceptance; the last result strobes as busy drops.
// register: 1..SLOTS allocator probes; divide by 1000 is four 16-bit digits by
// reciprocal multiply. check: e expired timers give e expired results first;
// unused kind: no result.
// synchronous reset clears the table; no clearing pass. the receiver cannot stall.
module timer_deadline_queue #(
   parameter int SLOTS = tdq_pkg::SLOTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tdq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output tdq_pkg::rsp_type rsp_data
);
   tdq_pkg::dp_cmd_type  cmd;
   tdq_pkg::dp_stat_type stat;
   logic [tdq_pkg::ID_W-1:0]  best_id, alloc_id;
   logic                      remove_ok;
   logic [tdq_pkg::TMO_W-1:0] tmo;

   tdq_datapath #(.SLOTS(SLOTS)) u_dp (
      .clock, .reset, .req_in(req_data), .cmd, .stat,
      .best_id, .alloc_id, .remove_ok, .tmo
   );

   tdq_ctrl u_ctrl (
      .clock, .reset, .start, .busy, .stat, .best_id, .alloc_id, .remove_ok, .tmo,
      .cmd, .rsp_strobe, .rsp_data
   );
endmodule

[test/tb_timer_deadline_queue.sv]
module tb_timer_deadline_queue;

   localparam int NSLOT = tdq_pkg::SLOTS_DEFAULT;
   localparam int LIMIT = 2000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   tdq_pkg::req_type req_data = '0;
   logic    rsp_strobe;
   tdq_pkg::rsp_type rsp_data;

   timer_deadline_queue #(.SLOTS(NSLOT)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the timer table
   logic        live [NSLOT];
   logic [63:0] due [NSLOT];
   logic [31:0] seq [NSLOT];
   int unsigned alloc_next;
   logic [31:0] seq_count;

   tdq_pkg::req_type pending_q[$];
   tdq_pkg::rsp_type expected_q[$];
   int      errors = 0;
   int      cycles = 0;
   bit      quiet = 0;
   int      gap = 0;

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic bit comes_first(int a, int b);
      logic [31:0] d;
      if (due[a] != due[b]) return due[a] < due[b];
      d = seq[a] - seq[b];
      return d[31];
   endfunction

   function automatic int earliest_slot();
      int best;
      best = -1;
      for (int i = 0; i < NSLOT; i++)
         if (live[i] && (best < 0 || comes_first(i, best))) best = i;
      return best;
   endfunction

   function automatic logic [15:0] reload_ms(int s, logic [63:0] now);
      logic [63:0] q;
      if (due[s] <= now) return '0;
      q = (due[s] - now) / 64'd1000;
      return q[15:0];
   endfunction

   function automatic tdq_pkg::rsp_type mk(tdq_pkg::res_kind_type rk, logic [5:0] id,
                                           logic ok, logic rv, logic [15:0] t,
                                           logic lst);
      tdq_pkg::rsp_type r;
      r.result_kind = rk; r.out_id = id; r.ok = ok;
      r.reload_valid = rv; r.timeout_ms = t; r.last = lst;
      return r;
   endfunction

   task automatic predict_queue(input tdq_pkg::req_type t);
      int unsigned st, c, id;
      int e, s;
      logic [64:0] sum;
      case (tdq_pkg::kind_type'(t.kind))
         tdq_pkg::KIND_REGISTER: begin
            st = (alloc_next < 1 || alloc_next > NSLOT) ? 1 : alloc_next;
            id = 0;
            for (int n = 0; n < NSLOT; n++) begin
               c = st + n;
               if (c > NSLOT) c -= NSLOT;
               if (!live[c-1]) begin
                  id = c;
                  break;
               end
            end
            if (id != 0) begin
               s = id - 1;
               sum = {1'b0, t.now_us} + {17'b0, t.delay_us};
               due[s] = sum[64] ? '1 : sum[63:0];
               live[s] = 1'b1;
               seq[s] = seq_count;
               seq_count++;
               alloc_next = (id >= NSLOT) ? 1 : id + 1;
            end
            e = earliest_slot();
            if (e >= 0)
               expected_q.push_back(mk(tdq_pkg::RES_REGISTERED, 6'(id), id != 0, 1'b1,
                                       reload_ms(e, t.now_us), 1'b1));
            else
               expected_q.push_back(mk(tdq_pkg::RES_REGISTERED, 6'(id), 1'b0, 1'b0, '0,
                                       1'b1));
         end
         tdq_pkg::KIND_REMOVE: begin
            id = 32'(t.timer_id);
            if (id >= 1 && id <= NSLOT && live[id-1]) begin
               live[id-1] = 1'b0;
               expected_q.push_back(mk(tdq_pkg::RES_REMOVE, '0, 1'b1, 1'b0, '0, 1'b1));
            end else
               expected_q.push_back(mk(tdq_pkg::RES_REMOVE, '0, 1'b0, 1'b0, '0, 1'b1));
         end
         tdq_pkg::KIND_CHECK: begin
            for (int n = 0; n < NSLOT; n++) begin
               e = earliest_slot();
               if (e < 0 || due[e] > t.now_us) break;
               expected_q.push_back(mk(tdq_pkg::RES_EXPIRED, 6'(e + 1), 1'b0, 1'b0, '0,
                                       1'b0));
               live[e] = 1'b0;
            end
            e = earliest_slot();
            if (e >= 0)
               expected_q.push_back(mk(tdq_pkg::RES_FINAL, '0, 1'b0, 1'b1,
                                       reload_ms(e, t.now_us), 1'b1));
            else
               expected_q.push_back(mk(tdq_pkg::RES_FINAL, '0, 1'b0, 1'b0, '0, 1'b1));
         end
         default: ;
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (start && !busy) begin
            predict_queue(req_data);
            void'(pending_q.pop_front());
         end
         if (start && busy) begin
            // hold the current transaction
         end else if (gap > 0) begin
            gap <= gap - 1;
            start <= 1'b0;
         end else if (pending_q.size() > 0) begin
            if (!quiet && $urandom_range(0, 5) == 0) begin
               gap <= $urandom_range(0, 4);
               start <= 1'b0;
            end else begin
               start <= 1'b1;
               req_data <= pending_q[0];
            end
         end else
            start <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_q.size() == 0)
            report_mismatch($sformatf("unexpected result %p", rsp_data));
         else begin
            if (rsp_data !== expected_q[0])
               report_mismatch($sformatf("got %p want %p", rsp_data, expected_q[0]));
            void'(expected_q.pop_front());
         end
      end
   end

   always @(posedge clock)
      if (cycles > LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end

   function automatic tdq_pkg::req_type mkreq(tdq_pkg::kind_type k, logic [63:0] now,
                                              logic [47:0] dly, logic [5:0] id);
      tdq_pkg::req_type r;
      r.kind = k; r.now_us = now; r.delay_us = dly; r.timer_id = id;
      return r;
   endfunction

   function automatic logic [63:0] rnd64();
      return {$urandom(), $urandom()};
   endfunction

   initial begin
      logic [63:0] clk_us;
      int k;
      for (int i = 0; i < NSLOT; i++) live[i] = 1'b0;
      alloc_next = 1;
      seq_count = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed
      pending_q.push_back(mkreq(tdq_pkg::KIND_CHECK, 64'd0, '0, '0));
      pending_q.push_back(mkreq(tdq_pkg::KIND_REMOVE, 64'd5, '0, 6'd0));
      pending_q.push_back(mkreq(tdq_pkg::KIND_REGISTER, 64'd1000, 48'd5000, '0));
      pending_q.push_back(mkreq(tdq_pkg::KIND_REGISTER, 64'd1000, 48'd5000, '0));
      pending_q.push_back(mkreq(tdq_pkg::KIND_REGISTER, '1, '1, '0));
      pending_q.push_back(mkreq(tdq_pkg::KIND_REGISTER, 64'd0, '1, '0));
      pending_q.push_back(mkreq(tdq_pkg::KIND_UNUSED, rnd64(), '1, '1));
      pending_q.push_back(mkreq(tdq_pkg::KIND_REMOVE, 64'd0, '0, 6'd33));
      pending_q.push_back(mkreq(tdq_pkg::KIND_REMOVE, 64'd0, '0, 6'd63));
      pending_q.push_back(mkreq(tdq_pkg::KIND_REMOVE, 64'd0, '0, 6'd20));
      pending_q.push_back(mkreq(tdq_pkg::KIND_REMOVE, 64'd0, '0, 6'd4));
      pending_q.push_back(mkreq(tdq_pkg::KIND_CHECK, 64'd7000, '0, '0));
      pending_q.push_back(mkreq(tdq_pkg::KIND_CHECK, 64'd6000, '0, '0));
      for (int i = 0; i < 9; i++)
         pending_q.push_back(mkreq(tdq_pkg::KIND_REGISTER, 64'd100, 48'(i * 700), '0));
      pending_q.push_back(mkreq(tdq_pkg::KIND_CHECK, '1, '0, '0));

      // random: mostly coherent time line, some noise
      clk_us = 64'd10_000;
      for (int i = 0; i < 310; i++) begin
         k = $urandom_range(0, 99);
         clk_us += 64'($urandom_range(0, 20000));
         if (k < 3) clk_us = rnd64();
         if (k < 50)
            pending_q.push_back(mkreq(tdq_pkg::KIND_REGISTER, clk_us,
               ($urandom_range(0, 9) == 0) ? 48'({$urandom(), $urandom()})
                                           : 48'($urandom_range(0, 70_000_000)), '0));
         else if (k < 70)
            pending_q.push_back(mkreq(tdq_pkg::KIND_REMOVE, clk_us, 48'($urandom()),
                                      6'($urandom_range(0, 63))));
         else if (k < 97)
            pending_q.push_back(mkreq(tdq_pkg::KIND_CHECK, clk_us, 48'($urandom()),
                                      6'($urandom())));
         else
            pending_q.push_back(mkreq(tdq_pkg::KIND_UNUSED, clk_us, '0, '0));
      end
      // last part of the run goes without idling
      wait (pending_q.size() <= 50);
      quiet = 1;
      wait (pending_q.size() == 0 && !start);
      wait (expected_q.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule

[sim.f]
hdl/tdq_pkg.sv
hdl/tdq_datapath.sv
hdl/tdq_ctrl.sv
hdl/timer_deadline_queue.sv
test/tb_timer_deadline_queue.sv
